// File: rtl/ray_fragment_radiance_gather_assert.svh
// Assertion macros for the radiance gather RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef RAY_FRAGMENT_RADIANCE_GATHER_ASSERT_SVH
`define RAY_FRAGMENT_RADIANCE_GATHER_ASSERT_SVH
`ifndef SYNTHESIS
`define RFRG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define RFRG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RFRG_ASSERT_IMP(lbl, ante, cons, msg)
`define RFRG_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/rfrg_pkg.sv
// Shared types, constants and fixed-point helpers for the radiance gather.
// No dependencies.
package rfrg_pkg;

  localparam int unsigned POLYS_DEF    = 1024;
  localparam int unsigned ACC_BITS_DEF = 48;
  localparam int unsigned WORDS        = 17;
  localparam int unsigned ACC_WORDS    = 3;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_FRAG = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  localparam logic [2:0] CFG_DIR_X   = 3'd0;
  localparam logic [2:0] CFG_DIR_Y   = 3'd1;
  localparam logic [2:0] CFG_DIR_Z   = 3'd2;
  localparam logic [2:0] CFG_WEIGHT  = 3'd3;
  localparam logic [2:0] CFG_AREA    = 3'd4;
  localparam logic [2:0] CFG_SKY     = 3'd5;

  // Table word layout of one patch.
  localparam logic [4:0] W_NX  = 5'd0;
  localparam logic [4:0] W_NY  = 5'd1;
  localparam logic [4:0] W_NZ  = 5'd2;
  localparam logic [4:0] W_OX  = 5'd3;
  localparam logic [4:0] W_OY  = 5'd4;
  localparam logic [4:0] W_OZ  = 5'd5;
  localparam logic [4:0] W_EUX = 5'd6;
  localparam logic [4:0] W_EUY = 5'd7;
  localparam logic [4:0] W_EUZ = 5'd8;
  localparam logic [4:0] W_EVX = 5'd9;
  localparam logic [4:0] W_EVY = 5'd10;
  localparam logic [4:0] W_EVZ = 5'd11;
  localparam logic [4:0] W_E0  = 5'd12;
  localparam logic [4:0] W_E1  = 5'd13;
  localparam logic [4:0] W_E2  = 5'd14;
  localparam logic [4:0] W_EM  = 5'd15;
  localparam logic [4:0] W_RHO = 5'd16;

  // 1/pi in Q0.32.
  localparam logic signed [31:0] INV_PI_Q32 = 32'sd1367130551;

  localparam int unsigned STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_CHECK = 5'd27;
  localparam logic [STEP_W-1:0] STEP_LAST  = 5'd31;

  typedef struct packed {
    logic              capture;
    logic              clr_en;
    logic              load_we;
    logic              acc_rd_issue;
    logic              acc_rd_finish;
    logic              frag_en;
    logic [STEP_W-1:0] step;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic deposit;
  } sts_t;

  // Round a Q32.32 product to Q32.16, half up.
  function automatic logic signed [47:0] rnd16(input logic signed [63:0] x);
    logic signed [63:0] t;
    t = x + 64'sd32768;
    return t[63:16];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

endpackage

// File: rtl/rfrg_ctrl.sv
// Controller of the radiance gather: sequences clear, load, read and fragment work.
// Depends on rfrg_pkg and the assertion macro header.
`include "ray_fragment_radiance_gather_assert.svh"
module rfrg_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  rfrg_pkg::sts_t     sts_i,
  output rfrg_pkg::cmd_t     cmd_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_READ0 = 3'd3;
  localparam logic [2:0] S_READ1 = 3'd4;
  localparam logic [2:0] S_FRAG  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]                  state_q, state_d;
  logic [rfrg_pkg::STEP_W-1:0] step_q, step_d;
  logic                        out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    cmd_o.step = step_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          step_d = '0;
          case (mode_i)
            rfrg_pkg::MODE_LOAD: state_d = S_LOAD;
            rfrg_pkg::MODE_FRAG: state_d = S_FRAG;
            rfrg_pkg::MODE_READ: state_d = S_READ0;
            default:             state_d = S_DONE;
          endcase
        end
      end
      S_LOAD: begin
        cmd_o.load_we = 1'b1;
        state_d = S_DONE;
      end
      S_READ0: begin
        cmd_o.acc_rd_issue = 1'b1;
        state_d = S_READ1;
      end
      S_READ1: begin
        cmd_o.acc_rd_finish = 1'b1;
        state_d = S_DONE;
      end
      S_FRAG: begin
        cmd_o.frag_en = 1'b1;
        step_d = step_q + 1'b1;
        // Without a deposit the accumulator steps are skipped.
        if ((step_q == rfrg_pkg::STEP_CHECK && !sts_i.deposit) ||
            step_q == rfrg_pkg::STEP_LAST) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  `RFRG_ASSERT_IMP(a_no_result_in_clear, state_q == S_CLEAR, !out_valid_q,
                   "result shown during clearing pass")
  `RFRG_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, state_q != S_IDLE,
                   "block idle right after a request")
  `RFRG_ASSERT_NXT(a_done_waits, state_q == S_DONE && out_valid_q && out_stall_i,
                   state_q == S_DONE && out_valid_q, "finished result dropped")

endmodule

// File: rtl/rfrg_dp.sv
// Datapath of the radiance gather: patch table, accumulator memory, shared multiplier.
// Depends on rfrg_pkg; steered by rfrg_ctrl through cmd_t.
module rfrg_dp #(
  parameter int unsigned POLYS    = rfrg_pkg::POLYS_DEF,
  parameter int unsigned ACC_BITS = rfrg_pkg::ACC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rfrg_pkg::cmd_t      cmd_i,
  output rfrg_pkg::sts_t      sts_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [30:0]         cfg_data_i,
  input  logic [1:0]          mode_i,
  input  logic [9:0]          poly_index_i,
  input  logic [4:0]          word_sel_i,
  input  logic signed [31:0]  load_value_i,
  input  logic signed [31:0]  frag_depth_i,
  input  logic signed [31:0]  ray_x_i,
  input  logic signed [31:0]  ray_y_i,
  input  logic signed [31:0]  ray_z_i,
  input  logic                first_of_ray_i,
  output logic signed [47:0]  read_data_o,
  output logic                pair_added_o
);

  localparam int unsigned TBL_DEPTH = POLYS * rfrg_pkg::WORDS;
  localparam int unsigned ACC_DEPTH = POLYS * rfrg_pkg::ACC_WORDS;
  localparam int unsigned TW = $clog2(TBL_DEPTH);
  localparam int unsigned AW = $clog2(ACC_DEPTH);
  localparam int unsigned SW = ((ACC_BITS > 48) ? ACC_BITS : 48) + 1;
  localparam logic signed [SW-1:0] ACC_HI = (SW'(1) <<< (ACC_BITS - 1)) - SW'(1);
  localparam logic signed [SW-1:0] ACC_LO = -ACC_HI - SW'(1);
  localparam logic signed [SW-1:0] RD_HI  = (SW'(1) <<< 47) - SW'(1);
  localparam logic signed [SW-1:0] RD_LO  = -RD_HI - SW'(1);

  // Configuration registers.
  logic signed [17:0] dir_x_q, dir_y_q, dir_z_q;
  logic [30:0]        weight_q, area_q, sky_q;

  // Captured request.
  logic [1:0]         mode_q;
  logic [9:0]         k_q;
  logic [4:0]         sel_q;
  logic signed [31:0] load_q, depth_q, rx_q, ry_q, rz_q;
  logic               first_q;

  // Ray history.
  logic [9:0]         prev_patch_q;
  logic               prev_valid_q;
  logic signed [31:0] prev_u_q, prev_v_q;

  // Working registers.
  logic signed [63:0] prod_q;
  logic signed [51:0] sum_q;
  logic signed [31:0] q0_q, q1_q, q2_q;
  logic signed [49:0] uacc_q, vacc_q, e_q;
  logic signed [31:0] s_q, em_q, l_q, g_q, c_q;
  logic signed [47:0] cu_q, cv_q;
  logic               nw_neg_q, face_pos_q;
  logic signed [47:0] res_rd_q;
  logic signed [47:0] out_data_q;
  logic               out_pair_q;

  // Memories.
  logic signed [31:0]       tbl_mem [TBL_DEPTH];
  logic signed [31:0]       tbl_rd_q;
  logic [ACC_BITS-1:0]      acc_mem [ACC_DEPTH];
  logic [ACC_BITS-1:0]      acc_rd_q;
  logic [AW-1:0]            acc_waddr_q;
  logic [AW-1:0]            clr_q;

  logic               k_ok, sel_load_ok, sel_read_ok, is_frag, deposit, prev_eff;
  logic [TW-1:0]      base_k, base_p, tbl_raddr, tbl_base;
  logic [4:0]         tbl_word;
  logic [AW-1:0]      base3, acc_raddr, acc_addr_w;
  logic               acc_we;
  logic [ACC_BITS-1:0] acc_wdata;
  logic signed [47:0] acc_delta;
  logic signed [SW-1:0] acc_sum, acc_ext;
  logic signed [31:0] mul_a, mul_b;
  logic signed [31:0] u_sat, v_sat, e_clamp, l_sel, l_rad;
  logic signed [63:0] scat_t;
  logic signed [47:0] rnd_p;

  assign k_ok        = (32'(k_q) < 32'(POLYS));
  assign sel_load_ok = (sel_q < 5'(rfrg_pkg::WORDS));
  assign sel_read_ok = (sel_q < 5'(rfrg_pkg::ACC_WORDS));
  assign is_frag     = (mode_q == rfrg_pkg::MODE_FRAG);
  assign prev_eff    = prev_valid_q && !first_q;
  assign deposit     = is_frag && k_ok && nw_neg_q && (l_q > 32'sd0);

  assign base_k = (TW'(k_q) << 4) + TW'(k_q);
  assign base_p = (TW'(prev_patch_q) << 4) + TW'(prev_patch_q);
  assign base3  = (AW'(k_q) << 1) + AW'(k_q);

  assign rnd_p  = rfrg_pkg::rnd16(prod_q);
  assign u_sat  = rfrg_pkg::sat32(64'(uacc_q));
  assign v_sat  = rfrg_pkg::sat32(64'(vacc_q));
  assign e_clamp = (e_q < 50'sd0) ? 32'sd0 : rfrg_pkg::sat32(64'(e_q));
  assign scat_t = prod_q + 64'sh80000000;
  assign l_rad  = rfrg_pkg::sat32(64'(em_q) + 64'(scat_t[63:32]));
  assign l_sel  = !prev_eff ? $signed({1'b0, sky_q}) : (face_pos_q ? l_rad : 32'sd0);

  assign sts_o.clr_last = (32'(clr_q) == 32'(ACC_DEPTH - 1));
  assign sts_o.deposit  = deposit;

  // Table read address for each fragment step; the data is registered and arrives in the next cycle.
  always_comb begin
    tbl_base = base_k;
    tbl_word = rfrg_pkg::W_NX;
    case (cmd_i.step)
      5'd0:  tbl_word = rfrg_pkg::W_NX;
      5'd1:  tbl_word = rfrg_pkg::W_NY;
      5'd2:  tbl_word = rfrg_pkg::W_NZ;
      5'd4:  tbl_word = rfrg_pkg::W_OX;
      5'd5:  tbl_word = rfrg_pkg::W_OY;
      5'd6:  tbl_word = rfrg_pkg::W_OZ;
      5'd7:  tbl_word = rfrg_pkg::W_EUX;
      5'd8:  tbl_word = rfrg_pkg::W_EUY;
      5'd9:  tbl_word = rfrg_pkg::W_EUZ;
      5'd10: tbl_word = rfrg_pkg::W_EVX;
      5'd11: tbl_word = rfrg_pkg::W_EVY;
      5'd12: tbl_word = rfrg_pkg::W_EVZ;
      5'd13: begin tbl_base = base_p; tbl_word = rfrg_pkg::W_NX;  end
      5'd14: begin tbl_base = base_p; tbl_word = rfrg_pkg::W_NY;  end
      5'd15: begin tbl_base = base_p; tbl_word = rfrg_pkg::W_NZ;  end
      5'd16: begin tbl_base = base_p; tbl_word = rfrg_pkg::W_E1;  end
      5'd17: begin tbl_base = base_p; tbl_word = rfrg_pkg::W_E2;  end
      5'd18: begin tbl_base = base_p; tbl_word = rfrg_pkg::W_E0;  end
      5'd19: begin tbl_base = base_p; tbl_word = rfrg_pkg::W_RHO; end
      5'd20: begin tbl_base = base_p; tbl_word = rfrg_pkg::W_EM;  end
      default: tbl_word = rfrg_pkg::W_NX;
    endcase
    tbl_raddr = tbl_base + TW'(tbl_word);
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = 32'sd0;
    mul_b = 32'sd0;
    if (cmd_i.frag_en) begin
      case (cmd_i.step)
        5'd1, 5'd14: begin mul_a = tbl_rd_q; mul_b = 32'(dir_x_q); end
        5'd2, 5'd15: begin mul_a = tbl_rd_q; mul_b = 32'(dir_y_q); end
        5'd3, 5'd16: begin mul_a = tbl_rd_q; mul_b = 32'(dir_z_q); end
        5'd4:  begin mul_a = depth_q;  mul_b = 32'(dir_x_q); end
        5'd5:  begin mul_a = depth_q;  mul_b = 32'(dir_y_q); end
        5'd6:  begin mul_a = depth_q;  mul_b = 32'(dir_z_q); end
        5'd8, 5'd11:  begin mul_a = q0_q; mul_b = tbl_rd_q; end
        5'd9, 5'd12:  begin mul_a = q1_q; mul_b = tbl_rd_q; end
        5'd10, 5'd13: begin mul_a = q2_q; mul_b = tbl_rd_q; end
        5'd17: begin mul_a = tbl_rd_q; mul_b = prev_u_q; end
        5'd18: begin mul_a = tbl_rd_q; mul_b = prev_v_q; end
        5'd20: begin mul_a = tbl_rd_q; mul_b = e_clamp; end
        5'd22: begin mul_a = s_q; mul_b = rfrg_pkg::INV_PI_Q32; end
        5'd24: begin mul_a = $signed({1'b0, weight_q}); mul_b = $signed({1'b0, area_q}); end
        5'd26: begin mul_a = g_q; mul_b = l_q; end
        5'd28: begin mul_a = c_q; mul_b = u_sat; end
        5'd29: begin mul_a = c_q; mul_b = v_sat; end
        default: begin mul_a = 32'sd0; mul_b = 32'sd0; end
      endcase
    end
  end

  // Accumulator port: outside the clearing pass, a write lands on the address read in the previous cycle.
  always_comb begin
    acc_raddr = base3;
    if (cmd_i.acc_rd_issue) begin
      acc_raddr = base3 + AW'(sel_q[1:0]);
    end else begin
      case (cmd_i.step)
        5'd29:   acc_raddr = base3 + AW'(1);
        5'd30:   acc_raddr = base3 + AW'(2);
        default: acc_raddr = base3;
      endcase
    end
    acc_delta = 48'(c_q);
    case (cmd_i.step)
      5'd30:   acc_delta = cu_q;
      5'd31:   acc_delta = cv_q;
      default: acc_delta = 48'(c_q);
    endcase
    acc_ext = SW'($signed(acc_rd_q));
    acc_sum = acc_ext + SW'(acc_delta);
    if (acc_sum > ACC_HI) begin
      acc_sum = ACC_HI;
    end else if (acc_sum < ACC_LO) begin
      acc_sum = ACC_LO;
    end
    acc_we     = 1'b0;
    acc_addr_w = acc_waddr_q;
    acc_wdata  = '0;
    if (cmd_i.clr_en) begin
      acc_we     = 1'b1;
      acc_addr_w = clr_q;
    end else if (cmd_i.acc_rd_finish) begin
      acc_we = k_ok && sel_read_ok;
    end else if (cmd_i.frag_en && cmd_i.step >= 5'd29) begin
      acc_we    = deposit;
      acc_wdata = acc_sum[ACC_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    tbl_rd_q <= tbl_mem[tbl_raddr];
    if (cmd_i.load_we && k_ok && sel_load_ok) begin
      tbl_mem[base_k + TW'(sel_q)] <= load_q;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_rd_q    <= acc_mem[acc_raddr];
    acc_waddr_q <= acc_raddr;
    if (acc_we) begin
      acc_mem[acc_addr_w] <= acc_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_x_q  <= 18'sd0;
      dir_y_q  <= 18'sd0;
      dir_z_q  <= 18'sd65536;
      weight_q <= '0;
      area_q   <= '0;
      sky_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rfrg_pkg::CFG_DIR_X:  dir_x_q  <= cfg_data_i[17:0];
        rfrg_pkg::CFG_DIR_Y:  dir_y_q  <= cfg_data_i[17:0];
        rfrg_pkg::CFG_DIR_Z:  dir_z_q  <= cfg_data_i[17:0];
        rfrg_pkg::CFG_WEIGHT: weight_q <= cfg_data_i;
        rfrg_pkg::CFG_AREA:   area_q   <= cfg_data_i;
        rfrg_pkg::CFG_SKY:    sky_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_patch_q <= '0;
      prev_valid_q <= 1'b0;
      prev_u_q     <= '0;
      prev_v_q     <= '0;
    end else if (cmd_i.out_load && is_frag && k_ok) begin
      // Every in-range fragment becomes the upstream one for the next.
      prev_patch_q <= k_q;
      prev_valid_q <= 1'b1;
      prev_u_q     <= u_sat;
      prev_v_q     <= v_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (cmd_i.capture) begin
      mode_q  <= mode_i;
      k_q     <= poly_index_i;
      sel_q   <= word_sel_i;
      load_q  <= load_value_i;
      depth_q <= frag_depth_i;
      rx_q    <= ray_x_i;
      ry_q    <= ray_y_i;
      rz_q    <= ray_z_i;
      first_q <= first_of_ray_i;
      res_rd_q <= '0;
    end
    if (cmd_i.acc_rd_finish) begin
      if (k_ok && sel_read_ok) begin
        if (acc_ext > RD_HI) begin
          res_rd_q <= RD_HI[47:0];
        end else if (acc_ext < RD_LO) begin
          res_rd_q <= RD_LO[47:0];
        end else begin
          res_rd_q <= acc_ext[47:0];
        end
      end else begin
        res_rd_q <= '0;
      end
    end
    if (cmd_i.frag_en) begin
      case (cmd_i.step)
        5'd2, 5'd15: sum_q <= prod_q[51:0];
        5'd3, 5'd4, 5'd16, 5'd17: sum_q <= sum_q + prod_q[51:0];
        5'd5: begin
          nw_neg_q <= (sum_q < 52'sd0);
          q0_q <= rfrg_pkg::sat32(64'(rx_q) + 64'(rnd_p) - 64'(tbl_rd_q));
        end
        5'd6:  q1_q <= rfrg_pkg::sat32(64'(ry_q) + 64'(rnd_p) - 64'(tbl_rd_q));
        5'd7:  q2_q <= rfrg_pkg::sat32(64'(rz_q) + 64'(rnd_p) - 64'(tbl_rd_q));
        5'd9:  uacc_q <= 50'(rnd_p);
        5'd10, 5'd11: uacc_q <= uacc_q + 50'(rnd_p);
        5'd12: vacc_q <= 50'(rnd_p);
        5'd13, 5'd14: vacc_q <= vacc_q + 50'(rnd_p);
        5'd18: begin
          face_pos_q <= (sum_q > 52'sd0);
          e_q <= 50'(rnd_p);
        end
        5'd19: e_q <= e_q + 50'(rnd_p) + 50'(tbl_rd_q);
        5'd21: begin
          s_q  <= rfrg_pkg::sat32(64'(rnd_p));
          em_q <= tbl_rd_q;
        end
        5'd23: l_q  <= l_sel;
        5'd25: g_q  <= rfrg_pkg::sat32(64'(rnd_p));
        5'd27: c_q  <= rfrg_pkg::sat32(64'(rnd_p));
        5'd29: cu_q <= rnd_p;
        5'd30: cv_q <= rnd_p;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= (mode_q == rfrg_pkg::MODE_READ) ? res_rd_q : 48'sd0;
      out_pair_q <= deposit;
    end
  end

  assign read_data_o  = out_data_q;
  assign pair_added_o = out_pair_q;

endmodule

// File: rtl/ray_fragment_radiance_gather.sv
// Radiance gather over depth-sorted ray fragments: top level joining controller and datapath.
// Depends on rfrg_pkg, rfrg_ctrl and rfrg_dp.
// After reset the block runs a clearing pass over the accumulator memory and stalls
// requests until it ends. Requests are handled one at a time; a fragment without a
// deposit skips the accumulator steps and ends sooner than one with a deposit. The
// fragment time is set by the single shared 32x32 multiplier, through which every
// product of the hit point, patch coordinates, upstream radiance and deposit passes
// in turn, and by the one read port of the patch table. A new request is accepted
// while a finished result still waits at the output.
module ray_fragment_radiance_gather #(
  parameter int unsigned POLYS    = rfrg_pkg::POLYS_DEF,
  parameter int unsigned ACC_BITS = rfrg_pkg::ACC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [30:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic [9:0]         poly_index_i,
  input  logic [4:0]         word_sel_i,
  input  logic signed [31:0] load_value_i,
  input  logic signed [31:0] frag_depth_i,
  input  logic signed [31:0] ray_x_i,
  input  logic signed [31:0] ray_y_i,
  input  logic signed [31:0] ray_z_i,
  input  logic               first_of_ray_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [47:0] read_data_o,
  output logic               pair_added_o
);

  rfrg_pkg::cmd_t cmd;
  rfrg_pkg::sts_t sts;

  rfrg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rfrg_dp #(
    .POLYS    (POLYS),
    .ACC_BITS (ACC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .mode_i         (mode_i),
    .poly_index_i   (poly_index_i),
    .word_sel_i     (word_sel_i),
    .load_value_i   (load_value_i),
    .frag_depth_i   (frag_depth_i),
    .ray_x_i        (ray_x_i),
    .ray_y_i        (ray_y_i),
    .ray_z_i        (ray_z_i),
    .first_of_ray_i (first_of_ray_i),
    .read_data_o    (read_data_o),
    .pair_added_o   (pair_added_o)
  );

endmodule
